// ===== hdl/fast_atan2_approx_macros.svh =====
// ----------------------------------------------------------------------------
// fast_atan2_approx assertion macros
// shared concurrent assertion forms for the atan2 pipeline
// ----------------------------------------------------------------------------
`ifndef FAST_ATAN2_APPROX_MACROS_SVH
`define FAST_ATAN2_APPROX_MACROS_SVH

// same-cycle implication
`define FA2_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FA2_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fa2_pkg.sv =====
// ----------------------------------------------------------------------------
// fa2_pkg
// constants, widths and shared types of the cubic atan2 pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fa2_pkg;

  localparam int COORD_WIDTH_DEF     = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 13;

  localparam int R_FRAC     = 15;
  localparam int QUO_WIDTH  = R_FRAC + 1;
  localparam int DIV_STAGES = QUO_WIDTH;

  localparam int COEF_CUBE_WIDTH = 13;
  localparam int COEF_LIN_WIDTH  = 15;
  localparam logic [COEF_CUBE_WIDTH-1:0] COEF_CUBE = 13'd5967;
  localparam logic [COEF_LIN_WIDTH-1:0]  COEF_LIN  = 15'd31703;

  localparam int BASE_FRAC   = 30;
  localparam int BASE_WIDTH  = 32;
  localparam int SUM_FRAC    = 60;
  localparam int Q2_WIDTH    = 31;
  localparam int LIN_M_WIDTH = 30;
  localparam int C2_WIDTH    = 43;
  localparam int C3_WIDTH    = 58;
  localparam int P_WIDTH     = 60;
  localparam int TOTAL_WIDTH = 64;

  localparam logic [BASE_WIDTH-1:0]  QUARTER_PI_Q30       = 32'd843314857;
  localparam logic [BASE_WIDTH-1:0]  THREE_QUARTER_PI_Q30 = 32'd2529944570;
  localparam logic [TOTAL_WIDTH-1:0] PI_Q30               = 64'd3373259426;

  typedef struct packed {
    logic zero_den;
    logic r_neg;
    logic far_half;
    logic y_neg;
  } fa2_flags_t;

  // pi rounded to the output fraction width
  function automatic logic [TOTAL_WIDTH-1:0] pi_limit(input int frac_bits);
    return (PI_Q30 + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
  endfunction

endpackage

// ===== hdl/fa2_coord_if.sv =====
// ----------------------------------------------------------------------------
// fa2_coord_if
// valid/ready channel carrying one (x, y) request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fa2_coord_if import fa2_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink (input valid, input coord_x, input coord_y, output ready);
endinterface

// ===== hdl/fa2_angle_if.sv =====
// ----------------------------------------------------------------------------
// fa2_angle_if
// valid/ready channel carrying one angle result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fa2_angle_if import fa2_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic signed [ANGLE_FRAC_BITS+2:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

// ===== hdl/fa2_front.sv =====
// ----------------------------------------------------------------------------
// fa2_front
// operand stage: |y|, octant select, numerator magnitude and denominator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fa2_front import fa2_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [COORD_WIDTH-1:0] coord_x,
  input  logic [COORD_WIDTH-1:0] coord_y,
  output logic                   out_valid,
  output logic [COORD_WIDTH:0]   num_mag,
  output logic [COORD_WIDTH+1:0] den,
  output fa2_flags_t             out_flags
);

  localparam int EW = COORD_WIDTH + 2;

  logic          y_neg;
  logic          far_half;
  logic [EW-1:0] x_ext;
  logic [EW-1:0] y_ext;
  logic [EW-1:0] a_ext;
  logic [EW-1:0] num_s;
  logic [EW-1:0] den_s;
  logic [EW-1:0] num_abs;

  always_comb begin
    y_neg    = coord_y[COORD_WIDTH-1];
    far_half = coord_x[COORD_WIDTH-1];
    x_ext    = {{2{coord_x[COORD_WIDTH-1]}}, coord_x};
    y_ext    = {{2{coord_y[COORD_WIDTH-1]}}, coord_y};
    a_ext    = y_neg ? (EW'(0) - y_ext) : y_ext;
    num_s    = far_half ? (x_ext + a_ext) : (x_ext - a_ext);
    den_s    = far_half ? (a_ext - x_ext) : (x_ext + a_ext);
    num_abs  = num_s[EW-1] ? (EW'(0) - num_s) : num_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_mag            <= num_abs[COORD_WIDTH:0];
      den                <= den_s;
      out_flags.zero_den <= (den_s == '0);
      out_flags.r_neg    <= num_s[EW-1];
      out_flags.far_half <= far_half;
      out_flags.y_neg    <= y_neg;
    end
  end

endmodule

// ===== hdl/fa2_div.sv =====
// ----------------------------------------------------------------------------
// fa2_div
// restoring divider, one quotient bit per stage, |num| / den in Q1.15
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fa2_div import fa2_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [COORD_WIDTH:0]   num_mag,
  input  logic [COORD_WIDTH+1:0] den,
  input  fa2_flags_t             in_flags,
  output logic                   out_valid,
  output logic [QUO_WIDTH-1:0]   quo,
  output fa2_flags_t             out_flags
);

  localparam int DW = COORD_WIDTH + 2;
  localparam int RW = COORD_WIDTH + 3;

  logic                 s_valid [DIV_STAGES];
  logic [RW-1:0]        s_rem   [DIV_STAGES];
  logic [DW-1:0]        s_den   [DIV_STAGES];
  logic [QUO_WIDTH-1:0] s_quo   [DIV_STAGES];
  fa2_flags_t           s_flags [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [RW-1:0]        trial;
    logic [DW-1:0]        den_src;
    logic [QUO_WIDTH-1:0] quo_src;
    fa2_flags_t           flags_src;
    logic                 valid_src;
    logic                 fits;

    if (i == 0) begin : g_first
      assign trial     = {2'b00, num_mag};
      assign den_src   = den;
      assign quo_src   = '0;
      assign flags_src = in_flags;
      assign valid_src = in_valid;
    end else begin : g_next
      assign trial     = {s_rem[i-1][RW-2:0], 1'b0};
      assign den_src   = s_den[i-1];
      assign quo_src   = s_quo[i-1];
      assign flags_src = s_flags[i-1];
      assign valid_src = s_valid[i-1];
    end

    assign fits = (trial >= {1'b0, den_src});

    always_ff @(posedge clk) begin
      if (rst) begin
        s_valid[i] <= 1'b0;
      end else if (en) begin
        s_valid[i] <= valid_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_rem[i]   <= fits ? (trial - {1'b0, den_src}) : trial;
        s_den[i]   <= den_src;
        s_quo[i]   <= {quo_src[QUO_WIDTH-2:0], fits};
        s_flags[i] <= flags_src;
      end
    end
  end

  assign out_valid = s_valid[DIV_STAGES-1];
  assign quo       = s_quo[DIV_STAGES-1];
  assign out_flags = s_flags[DIV_STAGES-1];

endmodule

// ===== hdl/fa2_poly.sv =====
// ----------------------------------------------------------------------------
// fa2_poly
// cubic term and base angle, exact sum with 60 fraction bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fa2_poly import fa2_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [QUO_WIDTH-1:0]   quo,
  input  fa2_flags_t             in_flags,
  output logic                   out_valid,
  output logic [TOTAL_WIDTH-1:0] total,
  output fa2_flags_t             out_flags
);

  localparam logic [QUO_WIDTH-1:0] QUO_ONE = QUO_WIDTH'(1) << R_FRAC;
  localparam int SQ_W  = 2 * QUO_WIDTH;
  localparam int LIN_W = QUO_WIDTH + COEF_LIN_WIDTH;
  localparam int C2P_W = COEF_CUBE_WIDTH + Q2_WIDTH;
  localparam int C3P_W = C2_WIDTH + QUO_WIDTH;

  logic [4:0] v;

  logic [QUO_WIDTH-1:0]   q_eff;
  fa2_flags_t             flags_eff;
  logic [2*QUO_WIDTH-1:0] sq;
  logic [QUO_WIDTH+COEF_LIN_WIDTH-1:0] lin_prod;
  logic [COEF_CUBE_WIDTH+Q2_WIDTH-1:0] c2_prod;
  logic [C2_WIDTH+QUO_WIDTH-1:0]       c3_prod;
  logic [TOTAL_WIDTH-1:0] base_al;
  logic [TOTAL_WIDTH-1:0] p_ext;

  logic [QUO_WIDTH-1:0]   a_q;
  logic [Q2_WIDTH-1:0]    a_q2;
  logic [LIN_M_WIDTH-1:0] a_m1;
  fa2_flags_t             a_flags;
  logic [QUO_WIDTH-1:0]   b_q;
  logic [C2_WIDTH-1:0]    b_c2;
  logic [LIN_M_WIDTH-1:0] b_m1;
  fa2_flags_t             b_flags;
  logic [C3_WIDTH-1:0]    c_c3;
  logic [P_WIDTH-1:0]     c_lin;
  fa2_flags_t             c_flags;
  logic [P_WIDTH-1:0]     d_p;
  fa2_flags_t             d_flags;

  // origin takes r = -1
  always_comb begin
    q_eff           = in_flags.zero_den ? QUO_ONE : quo;
    flags_eff       = in_flags;
    flags_eff.r_neg = in_flags.zero_den | in_flags.r_neg;
    sq              = SQ_W'(q_eff) * SQ_W'(q_eff);
    lin_prod        = LIN_W'(q_eff) * LIN_W'(COEF_LIN);
    c2_prod         = C2P_W'(a_q2) * C2P_W'(COEF_CUBE);
    c3_prod         = C3P_W'(b_c2) * C3P_W'(b_q);
    base_al         = {2'b00, (d_flags.far_half ? THREE_QUARTER_PI_Q30 : QUARTER_PI_Q30),
                       {BASE_FRAC{1'b0}}};
    p_ext           = {{(TOTAL_WIDTH-P_WIDTH){1'b0}}, d_p};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_q       <= q_eff;
      a_q2      <= sq[Q2_WIDTH-1:0];
      a_m1      <= lin_prod[LIN_M_WIDTH-1:0];
      a_flags   <= flags_eff;

      b_q       <= a_q;
      b_c2      <= c2_prod[C2_WIDTH-1:0];
      b_m1      <= a_m1;
      b_flags   <= a_flags;

      c_c3      <= c3_prod[C3_WIDTH-1:0];
      c_lin     <= {b_m1, {BASE_FRAC{1'b0}}};
      c_flags   <= b_flags;

      d_p       <= c_lin - {{(P_WIDTH-C3_WIDTH){1'b0}}, c_c3};
      d_flags   <= c_flags;

      total     <= base_al + (d_flags.r_neg ? p_ext : (TOTAL_WIDTH'(0) - p_ext));
      out_flags <= d_flags;
    end
  end

  assign out_valid = v[4];

endmodule

// ===== hdl/fa2_round.sv =====
// ----------------------------------------------------------------------------
// fa2_round
// round to nearest away from zero, saturate to pi, apply the sign of y
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fa2_round import fa2_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [TOTAL_WIDTH-1:0]     total,
  input  fa2_flags_t                 in_flags,
  output logic                       out_valid,
  output logic [ANGLE_FRAC_BITS+2:0] angle
);

  localparam int OUT_WIDTH = ANGLE_FRAC_BITS + 3;
  localparam int SHIFT     = SUM_FRAC - ANGLE_FRAC_BITS;
  localparam int MAG_WIDTH = TOTAL_WIDTH - SHIFT;
  localparam logic [TOTAL_WIDTH-1:0] HALF  = TOTAL_WIDTH'(1) << (SHIFT - 1);
  localparam logic [MAG_WIDTH-1:0]   LIMIT = MAG_WIDTH'(pi_limit(ANGLE_FRAC_BITS));

  logic [2:0] v;

  logic [TOTAL_WIDTH-1:0] sum;
  logic [MAG_WIDTH-1:0]   sat;
  logic [OUT_WIDTH-1:0]   sat_o;
  logic                   flip;

  logic [TOTAL_WIDTH-1:0] r1_abs;
  logic                   r1_neg;
  logic                   r1_y_neg;
  logic [MAG_WIDTH-1:0]   r2_mag;
  logic                   r2_neg;
  logic                   r2_y_neg;

  always_comb begin
    sum   = r1_abs + HALF;
    sat   = (r2_mag > LIMIT) ? LIMIT : r2_mag;
    sat_o = sat[OUT_WIDTH-1:0];
    flip  = r2_neg ^ r2_y_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_abs   <= total[TOTAL_WIDTH-1] ? (TOTAL_WIDTH'(0) - total) : total;
      r1_neg   <= total[TOTAL_WIDTH-1];
      r1_y_neg <= in_flags.y_neg;

      r2_mag   <= sum[TOTAL_WIDTH-1:SHIFT];
      r2_neg   <= r1_neg;
      r2_y_neg <= r1_y_neg;

      angle    <= flip ? (OUT_WIDTH'(0) - sat_o) : sat_o;
    end
  end

  assign out_valid = v[2];

endmodule

// ===== hdl/fast_atan2_approx.sv =====
// ----------------------------------------------------------------------------
// fast_atan2_approx
// path: operand stage, divider stages, polynomial stages, rounding stages, output register
// throughput: one request per cycle unless the skid entry is full; the divider is a 16-stage pipeline
// a full output plus one skid entry stall the pipeline, nothing is dropped
// reset (rst, synchronous) clears all valid bits; no memory to clear
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fast_atan2_approx_macros.svh"

module fast_atan2_approx import fa2_pkg::*; #(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fa2_coord_if.sink   point,
  fa2_angle_if.source bearing
);

  localparam int OUT_WIDTH = ANGLE_FRAC_BITS + 3;
  localparam logic signed [OUT_WIDTH-1:0] ANGLE_MAX =
    OUT_WIDTH'(pi_limit(ANGLE_FRAC_BITS));

  logic en;

  logic                   f_valid;
  logic [COORD_WIDTH:0]   f_num;
  logic [COORD_WIDTH+1:0] f_den;
  fa2_flags_t             f_flags;

  logic                   d_valid;
  logic [QUO_WIDTH-1:0]   d_quo;
  fa2_flags_t             d_flags;

  logic                   p_valid;
  logic [TOTAL_WIDTH-1:0] p_total;
  fa2_flags_t             p_flags;

  logic                   pipe_valid;
  logic [OUT_WIDTH-1:0]   pipe_angle;

  logic                   out_valid;
  logic [OUT_WIDTH-1:0]   out_angle;
  logic                   sk_valid;
  logic [OUT_WIDTH-1:0]   sk_angle;
  logic                   out_free;

  assign en            = !sk_valid;
  assign point.ready   = en;
  assign bearing.valid = out_valid;
  assign bearing.angle = out_angle;
  assign out_free      = !out_valid || bearing.ready;

  fa2_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (point.valid),
    .coord_x   (point.coord_x),
    .coord_y   (point.coord_y),
    .out_valid (f_valid),
    .num_mag   (f_num),
    .den       (f_den),
    .out_flags (f_flags)
  );

  fa2_div #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num_mag   (f_num),
    .den       (f_den),
    .in_flags  (f_flags),
    .out_valid (d_valid),
    .quo       (d_quo),
    .out_flags (d_flags)
  );

  fa2_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .quo       (d_quo),
    .in_flags  (d_flags),
    .out_valid (p_valid),
    .total     (p_total),
    .out_flags (p_flags)
  );

  fa2_round #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .total     (p_total),
    .in_flags  (p_flags),
    .out_valid (pipe_valid),
    .angle     (pipe_angle)
  );

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (out_free) begin
      if (sk_valid) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end else begin
        out_valid <= en && pipe_valid;
      end
    end else if (en && pipe_valid) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_angle <= sk_valid ? sk_angle : pipe_angle;
    end else if (en && pipe_valid) begin
      sk_angle <= pipe_angle;
    end
  end

  `FA2_ASSERT_NOW(a_skid_behind_out, clk, rst, sk_valid, out_valid,
    "skid holds a result while output is empty")
  `FA2_ASSERT_NEXT(a_park_in_skid, clk, rst,
    out_valid && !bearing.ready && pipe_valid && en, sk_valid,
    "stalled result not parked in skid")
  `FA2_ASSERT_NEXT(a_skid_drain, clk, rst, sk_valid && bearing.ready,
    out_valid && !sk_valid, "skid entry not moved to output")
  `FA2_ASSERT_NOW(a_angle_range, clk, rst, out_valid,
    ($signed(out_angle) <= ANGLE_MAX) && ($signed(out_angle) >= -ANGLE_MAX),
    "angle beyond plus or minus pi")

endmodule

// ===== tb/fast_atan2_approx_checker.sv =====
// ----------------------------------------------------------------------------
// fast_atan2_approx_checker
// watches the point and bearing channels, predicts the cubic atan2 angle of
// every accepted point and compares each returned angle with the oldest one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fast_atan2_approx_checker import fa2_pkg::*; (
  input  logic clk,
  input  logic rst,
  fa2_coord_if point,
  fa2_angle_if bearing,
  output int   mismatches,
  output int   outstanding
);

  localparam int CW          = COORD_WIDTH_DEF;
  localparam int FRAC        = ANGLE_FRAC_BITS_DEF;
  localparam int ANGLE_W     = FRAC + 3;
  localparam int ROUND_SHIFT = SUM_FRAC - FRAC;

  typedef struct {
    logic signed [CW-1:0]      x;
    logic signed [CW-1:0]      y;
    logic signed [ANGLE_W-1:0] angle;
  } angle_due_t;

  angle_due_t angle_due [$];

  function automatic logic signed [ANGLE_W-1:0] atan2_estimate(
    input logic signed [CW-1:0] px,
    input logic signed [CW-1:0] py
  );
    longint          x, y, mag_y, num, den, base, ratio, poly, total;
    longint unsigned mag, cap;
    logic            flip;
    x     = longint'(px);
    y     = longint'(py);
    mag_y = (y < 0) ? -y : y;
    if (x >= 0) begin
      num  = x - mag_y;
      den  = x + mag_y;
      base = longint'(QUARTER_PI_Q30);
    end else begin
      num  = x + mag_y;
      den  = mag_y - x;
      base = longint'(THREE_QUARTER_PI_Q30);
    end
    // origin: ratio forced to -1
    if (den == 0) ratio = -(longint'(1) << R_FRAC);
    else ratio = (num * (longint'(1) << R_FRAC)) / den;
    poly  = longint'(COEF_CUBE) * (ratio * ratio) - longint'(COEF_LIN) * (longint'(1) << 30);
    total = base * (longint'(1) << BASE_FRAC) + poly * ratio;
    flip  = (total < 0);
    mag   = flip ? -total : total;
    mag   = (mag + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    cap   = (PI_Q30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    if (mag > cap) mag = cap;
    if (y < 0) flip = !flip;
    return flip ? -mag[ANGLE_W-1:0] : mag[ANGLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    angle_due_t want;
    int         errs;
    errs = mismatches;
    if (rst) begin
      angle_due.delete();
      errs = 0;
    end else begin
      if (bearing.valid && bearing.ready) begin
        if (angle_due.size() == 0) begin
          if (errs < 10) $display("angle %0d returned with no request pending", bearing.angle);
          errs++;
        end else begin
          want = angle_due.pop_front();
          if (bearing.angle !== want.angle) begin
            if (errs < 10) begin
              $display("angle mismatch x=%0d y=%0d: expected %0d, got %0d",
                       want.x, want.y, want.angle, bearing.angle);
            end
            errs++;
          end
        end
      end
      if (point.valid && point.ready) begin
        want.x     = point.coord_x;
        want.y     = point.coord_y;
        want.angle = atan2_estimate(point.coord_x, point.coord_y);
        angle_due.push_back(want);
      end
    end
    mismatches  <= errs;
    outstanding <= angle_due.size();
  end

endmodule

// ===== tb/fast_atan2_approx_tb.sv =====
// ----------------------------------------------------------------------------
// fast_atan2_approx_tb
// drives directed and random points into the atan2 pipeline with random
// idling, a long output hold-off and a full drain, and reports the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fast_atan2_approx_tb;
  import fa2_pkg::*;

  localparam int CW          = COORD_WIDTH_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   stall_cycles;
  bit   steady;
  int   hold_wanted;
  int   holds_done;

  fa2_coord_if point ();
  fa2_angle_if bearing ();

  fast_atan2_approx u_top (
    .clk     (clk),
    .rst     (rst),
    .point   (point),
    .bearing (bearing)
  );

  fast_atan2_approx_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .point       (point),
    .bearing     (bearing),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y);
    if (!steady) begin
      while ($urandom_range(0, 99) < 14) begin
        point.valid <= 1'b0;
        @(posedge clk);
      end
    end
    point.valid   <= 1'b1;
    point.coord_x <= x;
    point.coord_y <= y;
    @(posedge clk);
    while (!point.ready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    logic signed [CW-1:0] x, y;
    int                   kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      x    = CW'($urandom);
      y    = CW'($urandom);
      case (kind)
        6: begin
          x = CW'($urandom_range(0, 31) - 16);
          y = CW'($urandom_range(0, 31) - 16);
        end
        7: begin
          if ($urandom_range(0, 1)) x = '0;
          else y = '0;
        end
        8: begin
          y = ($urandom_range(0, 1)) ? x : -x;
        end
        9: begin
          x = ($urandom_range(0, 1)) ? 16'sh7fff - CW'($urandom_range(0, 3))
                                     : 16'sh8000 + CW'($urandom_range(0, 3));
        end
        default: begin
        end
      endcase
      send_point(x, y);
    end
  endtask

  initial begin
    rst           <= 1'b1;
    point.valid   <= 1'b0;
    point.coord_x <= '0;
    point.coord_y <= '0;
    steady         = 1'b0;
    hold_wanted    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // origin, both axes, saturation at pi and extremes
    send_point(16'sd0, 16'sd0);
    send_point(-16'sd100, 16'sd0);
    send_point(-16'sd1, 16'sd0);
    send_point(16'sh8000, 16'sd0);
    send_point(16'sd100, 16'sd0);
    send_point(16'sh7fff, 16'sd0);
    send_point(16'sd0, 16'sh7fff);
    send_point(16'sd0, 16'sh8000);
    send_point(16'sd0, 16'sd1);
    send_point(16'sd0, -16'sd1);
    send_point(16'sh7fff, 16'sh7fff);
    send_point(16'sh7fff, 16'sh8000);
    send_point(16'sh8000, 16'sh7fff);
    send_point(16'sh8000, 16'sh8000);
    send_point(16'sh8000, 16'sd1);
    send_point(16'sh8000, -16'sd1);
    send_point(16'sd1, 16'sh8000);
    send_point(16'sd1, 16'sd1);
    send_point(-16'sd1, -16'sd1);
    send_point(16'sh7fff, -16'sd1);
    send_point(16'sh5555, 16'shaaaa);

    send_random(150);
    // output held off while requests keep coming
    hold_wanted = 1;
    send_random(150);

    point.valid <= 1'b0;
    wait (outstanding == 0);
    @(posedge clk);

    steady = 1'b1;
    send_random(250);
    steady = 1'b0;
    send_random(250);

    point.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("fast_atan2_approx verification clean");
    end else begin
      $display("fast_atan2_approx verification failed");
    end
    $finish;
  end

  initial begin
    bearing.ready <= 1'b0;
    holds_done     = 0;
    forever begin
      @(posedge clk);
      if (holds_done < hold_wanted) begin
        holds_done++;
        bearing.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      bearing.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 14);
    end
  end

  always @(posedge clk) begin
    if (rst || (point.valid && point.ready) || (bearing.valid && bearing.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("fast_atan2_approx verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/fa2_pkg.sv
hdl/fa2_coord_if.sv
hdl/fa2_angle_if.sv
hdl/fa2_front.sv
hdl/fa2_div.sv
hdl/fa2_poly.sv
hdl/fa2_round.sv
hdl/fast_atan2_approx.sv
tb/fast_atan2_approx_checker.sv
tb/fast_atan2_approx_tb.sv
